// ===== hdl/csvt_pkg.sv =====
// Shared types and constants for the CSV record tokenizer.
package csvt_pkg;

  localparam int MAX_FIELDS = 16;
  localparam int BYTE_W     = 8;
  localparam int FIDX_W     = 4;
  localparam int FPR_W      = 5;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 8;

  localparam logic [BYTE_W-1:0] CH_QUOTE = 8'h22;
  localparam logic [BYTE_W-1:0] CH_COMMA = 8'h2C;
  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;

  localparam logic [CFG_IDX_W-1:0] CFG_FIELDS_PER_RECORD = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SKIP_HEADER       = 4'd1;

  typedef enum logic [1:0] {
    EV_DATA       = 2'd0,
    EV_FIELD_END  = 2'd1,
    EV_RECORD_END = 2'd2
  } ev_kind_t;

  typedef struct packed {
    logic [FPR_W-1:0] fields_per_record;
    logic             skip_header;
  } cfg_t;

  // Events caused by one byte, in order: lead field end, data byte,
  // a run of field ends lo..hi, then a record end at hi.
  typedef struct packed {
    logic              lead_en;
    logic [FIDX_W-1:0] lead_idx;
    logic              data_en;
    logic [FIDX_W-1:0] data_idx;
    logic [BYTE_W-1:0] data_byte;
    logic              rng_en;
    logic [FIDX_W-1:0] rng_lo;
    logic [FIDX_W-1:0] rng_hi;
    logic              rng_re;
  } desc_t;

  typedef struct packed {
    logic busy;
    logic drain;
  } emit_stat_t;

endpackage

// ===== hdl/csvt_in_if.sv =====
// Byte input channel of the CSV tokenizer.
interface csvt_in_if;
  logic                       valid;
  logic                       ready;
  logic [csvt_pkg::BYTE_W-1:0] data_byte;
  logic                       end_of_data;

  modport source (output valid, data_byte, end_of_data, input ready);
  modport sink (input valid, data_byte, end_of_data, output ready);
endinterface

// ===== hdl/csvt_out_if.sv =====
// Event output channel of the CSV tokenizer.
interface csvt_out_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  event_kind;
  logic [csvt_pkg::FIDX_W-1:0] field_index;
  logic [csvt_pkg::BYTE_W-1:0] field_byte;
  logic                        last_of_run;

  modport source (output valid, event_kind, field_index, field_byte, last_of_run,
                  input ready);
  modport sink (input valid, event_kind, field_index, field_byte, last_of_run,
                output ready);
endinterface

// ===== hdl/csvt_cfg_if.sv =====
// Register write channel of the CSV tokenizer.
interface csvt_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [csvt_pkg::CFG_IDX_W-1:0]  index;
  logic [csvt_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== hdl/csvt_parser.sv =====
// Parse state machine: decodes one byte into a run descriptor.
module csvt_parser (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        accept,
  input  logic [csvt_pkg::BYTE_W-1:0] data_byte,
  input  logic                        end_of_data,
  input  csvt_pkg::cfg_t              cfg,
  output csvt_pkg::desc_t             desc
);

  typedef enum logic [7:0] {
    M_STREAM_START = 8'b0000_0001,
    M_HEADER       = 8'b0000_0010,
    M_REC_START    = 8'b0000_0100,
    M_FIELD_START  = 8'b0000_1000,
    M_UNQUOTED     = 8'b0001_0000,
    M_QUOTED       = 8'b0010_0000,
    M_AFTER_QUOTE  = 8'b0100_0000,
    M_SKIP_LINE    = 8'b1000_0000
  } mode_t;

  mode_t                       mode, mode_next, m;
  logic [csvt_pkg::FIDX_W-1:0] fc, fc_next, f, f_max, nlast;
  logic                        done, done_next;
  logic                        is_quote, is_comma, is_cr, is_lf, is_crlf;
  logic                        take_field, at_start;
  csvt_pkg::desc_t             d;

  assign is_quote = data_byte == csvt_pkg::CH_QUOTE;
  assign is_comma = data_byte == csvt_pkg::CH_COMMA;
  assign is_cr    = data_byte == csvt_pkg::CH_CR;
  assign is_lf    = data_byte == csvt_pkg::CH_LF;
  assign is_crlf  = is_cr || is_lf;

  // Index of the record's last field; zero acts as one field.
  always_comb begin
    if (cfg.fields_per_record == '0) begin
      nlast = '0;
    end else if (cfg.fields_per_record > csvt_pkg::FPR_W'(csvt_pkg::MAX_FIELDS)) begin
      nlast = csvt_pkg::FIDX_W'(csvt_pkg::MAX_FIELDS - 1);
    end else begin
      nlast = csvt_pkg::FIDX_W'(cfg.fields_per_record - csvt_pkg::FPR_W'(1));
    end
  end

  always_comb begin
    if (mode == M_STREAM_START) begin
      m = cfg.skip_header ? M_HEADER : M_REC_START;
    end else begin
      m = mode;
    end
    f     = (m == M_REC_START) ? '0 : fc;
    f_max = (f > nlast) ? f : nlast;
  end

  always_comb begin
    d          = '0;
    mode_next  = mode;
    fc_next    = fc;
    done_next  = done;
    take_field = 1'b0;
    at_start   = 1'b0;
    if (!done) begin
      if (data_byte != '0) begin
        mode_next = m;
        case (m)
          M_HEADER, M_SKIP_LINE: begin
            if (is_lf) mode_next = M_REC_START;
          end
          M_REC_START: begin
            // blank lines are skipped
            if (!is_crlf) begin
              fc_next    = '0;
              take_field = 1'b1;
              at_start   = 1'b1;
            end
          end
          M_FIELD_START: begin
            take_field = 1'b1;
            at_start   = 1'b1;
          end
          M_UNQUOTED: begin
            take_field = 1'b1;
          end
          M_QUOTED: begin
            if (is_quote) begin
              mode_next = M_AFTER_QUOTE;
            end else begin
              d.data_en   = 1'b1;
              d.data_idx  = f;
              d.data_byte = data_byte;
            end
          end
          M_AFTER_QUOTE: begin
            if (is_quote) begin
              d.data_en   = 1'b1;
              d.data_idx  = f;
              d.data_byte = csvt_pkg::CH_QUOTE;
              mode_next   = M_QUOTED;
            end else if (is_comma) begin
              take_field = 1'b1;
              at_start   = 1'b1;
            end else if (f >= nlast) begin
              // stray byte closes the last field
              d.rng_en  = 1'b1;
              d.rng_lo  = f;
              d.rng_hi  = f;
              d.rng_re  = 1'b1;
              mode_next = is_lf ? M_REC_START : M_SKIP_LINE;
            end else if (is_crlf) begin
              d.rng_en  = 1'b1;
              d.rng_lo  = f;
              d.rng_hi  = nlast;
              d.rng_re  = 1'b1;
              fc_next   = f + 1'b1;
              mode_next = is_lf ? M_REC_START : M_SKIP_LINE;
            end else begin
              // stray byte ends this field and opens the next one
              d.lead_en   = 1'b1;
              d.lead_idx  = f;
              d.data_en   = 1'b1;
              d.data_idx  = f + 1'b1;
              d.data_byte = data_byte;
              fc_next     = f + 1'b1;
              mode_next   = M_UNQUOTED;
            end
          end
          default: ;
        endcase

        if (take_field) begin
          if (at_start && is_quote) begin
            mode_next = M_QUOTED;
          end else if (is_comma) begin
            d.rng_en = 1'b1;
            d.rng_lo = f;
            d.rng_hi = f;
            if (f >= nlast) begin
              d.rng_re  = 1'b1;
              mode_next = M_SKIP_LINE;
            end else begin
              fc_next   = f + 1'b1;
              mode_next = M_FIELD_START;
            end
          end else if (is_crlf) begin
            d.rng_en  = 1'b1;
            d.rng_lo  = f;
            d.rng_hi  = f_max;
            d.rng_re  = 1'b1;
            mode_next = is_lf ? M_REC_START : M_SKIP_LINE;
          end else begin
            d.data_en   = 1'b1;
            d.data_idx  = f;
            d.data_byte = data_byte;
            mode_next   = M_UNQUOTED;
          end
        end
      end

      // flush: close an open record, then end the stream
      if (data_byte == '0 || end_of_data) begin
        if (mode_next == M_FIELD_START || mode_next == M_UNQUOTED ||
            mode_next == M_QUOTED || mode_next == M_AFTER_QUOTE) begin
          if (!d.rng_en) begin
            d.rng_en = 1'b1;
            d.rng_lo = fc_next;
          end
          d.rng_hi = (fc_next > nlast) ? fc_next : nlast;
          d.rng_re = 1'b1;
        end
        if (mode_next == M_STREAM_START) begin
          mode_next = cfg.skip_header ? M_HEADER : M_REC_START;
        end else if (mode_next != M_HEADER) begin
          mode_next = M_REC_START;
        end
        done_next = 1'b1;
      end
    end
  end

  assign desc = d;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= M_STREAM_START;
      fc   <= '0;
      done <= 1'b0;
    end else if (accept) begin
      mode <= mode_next;
      fc   <= fc_next;
      done <= done_next;
    end
  end

endmodule

// ===== hdl/csvt_emitter.sv =====
// Run register and event sequencer: one event beat per cycle while events.ready is high.
module csvt_emitter (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  csvt_pkg::desc_t      desc,
  output csvt_pkg::emit_stat_t stat,
  csvt_out_if.source           events
);

  logic                        lead_p, data_p, rng_p, re_p;
  logic [csvt_pkg::FIDX_W-1:0] lead_idx, data_idx, cur, hi;
  logic [csvt_pkg::BYTE_W-1:0] data_b;

  logic                        n_lead, n_data, n_rng, n_re;
  csvt_pkg::ev_kind_t          pick_kind;
  logic [csvt_pkg::FIDX_W-1:0] pick_idx;
  logic [csvt_pkg::BYTE_W-1:0] pick_byte;
  logic                        last_pick, busy, step, load_out, rng_pick;

  logic                        ev_valid;
  csvt_pkg::ev_kind_t          ev_kind;
  logic [csvt_pkg::FIDX_W-1:0] ev_idx;
  logic [csvt_pkg::BYTE_W-1:0] ev_byte;
  logic                        ev_last;

  assign busy     = lead_p || data_p || rng_p || re_p;
  assign load_out = !ev_valid || events.ready;
  assign step     = load_out && busy;

  always_comb begin
    n_lead    = lead_p;
    n_data    = data_p;
    n_rng     = rng_p;
    n_re      = re_p;
    rng_pick  = 1'b0;
    pick_kind = csvt_pkg::EV_RECORD_END;
    pick_idx  = hi;
    pick_byte = '0;
    if (lead_p) begin
      pick_kind = csvt_pkg::EV_FIELD_END;
      pick_idx  = lead_idx;
      n_lead    = 1'b0;
    end else if (data_p) begin
      pick_kind = csvt_pkg::EV_DATA;
      pick_idx  = data_idx;
      pick_byte = data_b;
      n_data    = 1'b0;
    end else if (rng_p) begin
      pick_kind = csvt_pkg::EV_FIELD_END;
      pick_idx  = cur;
      rng_pick  = 1'b1;
      n_rng     = cur != hi;
    end else begin
      n_re = 1'b0;
    end
    last_pick = !(n_lead || n_data || n_rng || n_re);
  end

  assign stat.busy  = busy;
  assign stat.drain = step && last_pick;

  always_ff @(posedge clk) begin
    if (rst) begin
      lead_p   <= 1'b0;
      data_p   <= 1'b0;
      rng_p    <= 1'b0;
      re_p     <= 1'b0;
      ev_valid <= 1'b0;
    end else begin
      if (step) begin
        ev_valid <= 1'b1;
      end else if (events.ready) begin
        ev_valid <= 1'b0;
      end
      // a new run only lands once the old one has drained
      if (load) begin
        lead_p <= desc.lead_en;
        data_p <= desc.data_en;
        rng_p  <= desc.rng_en;
        re_p   <= desc.rng_re;
      end else if (step) begin
        lead_p <= n_lead;
        data_p <= n_data;
        rng_p  <= n_rng;
        re_p   <= n_re;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      ev_kind <= pick_kind;
      ev_idx  <= pick_idx;
      ev_byte <= pick_byte;
      ev_last <= last_pick;
    end
    if (load) begin
      lead_idx <= desc.lead_idx;
      data_idx <= desc.data_idx;
      data_b   <= desc.data_byte;
      cur      <= desc.rng_lo;
      hi       <= desc.rng_hi;
    end else if (step && rng_pick && n_rng) begin
      cur <= cur + 1'b1;
    end
  end

  assign events.valid       = ev_valid;
  assign events.event_kind  = ev_kind;
  assign events.field_index = ev_idx;
  assign events.field_byte  = ev_byte;
  assign events.last_of_run = ev_last;

endmodule

// ===== hdl/csv_record_tokenizer_core.sv =====
// Top level of the CSV record tokenizer: registers, parser and event sequencer.
//
//   channel   dir   beat payload
//   bytes     in    data_byte[7:0], end_of_data
//   events    out   event_kind[1:0], field_index[3:0], field_byte[7:0], last_of_run
//   cfg       in    index[3:0] (0 fields_per_record, 1 skip_header), data[7:0]
//
// A byte that causes k events (k at most 18) holds the sequencer until all are out;
// a byte causing zero or one event does not hold the next, so plain text runs at a
// byte per cycle while events.ready is high. Events cross run and output registers.
// Reset is synchronous: fields_per_record 6, skip_header 1, parser at stream start.
// A stalled events channel holds the output register; one further run waits
// in the run register, and bytes.ready drops while that run is not draining.
module csv_record_tokenizer_core (
  input logic        clk,
  input logic        rst,
  csvt_in_if.sink    bytes,
  csvt_out_if.source events,
  csvt_cfg_if.sink   cfg
);

  csvt_pkg::cfg_t       regs;
  csvt_pkg::desc_t      desc;
  csvt_pkg::emit_stat_t stat;
  logic                 in_acc;

  assign cfg.ready   = 1'b1;
  assign bytes.ready = !stat.busy || stat.drain;
  assign in_acc      = bytes.valid && bytes.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.fields_per_record <= csvt_pkg::FPR_W'(6);
      regs.skip_header       <= 1'b1;
    end else if (cfg.valid) begin
      case (cfg.index)
        csvt_pkg::CFG_FIELDS_PER_RECORD: regs.fields_per_record <= cfg.data[csvt_pkg::FPR_W-1:0];
        csvt_pkg::CFG_SKIP_HEADER:       regs.skip_header       <= cfg.data[0];
        default: ;
      endcase
    end
  end

  csvt_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .accept      (in_acc),
    .data_byte   (bytes.data_byte),
    .end_of_data (bytes.end_of_data),
    .cfg         (regs),
    .desc        (desc)
  );

  csvt_emitter u_emitter (
    .clk    (clk),
    .rst    (rst),
    .load   (in_acc),
    .desc   (desc),
    .stat   (stat),
    .events (events)
  );

  // last delivered event, for the ordering checks
  logic                        out_acc;
  logic [1:0]                  prev_kind;
  logic [csvt_pkg::FIDX_W-1:0] prev_idx;
  logic                        prev_last;

  assign out_acc = events.valid && events.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_kind <= csvt_pkg::EV_RECORD_END;
      prev_idx  <= '0;
      prev_last <= 1'b1;
    end else if (out_acc) begin
      prev_kind <= events.event_kind;
      prev_idx  <= events.field_index;
      prev_last <= events.last_of_run;
    end
  end

  a_re_after_fe: assert property (@(posedge clk) disable iff (rst)
    out_acc && events.event_kind == csvt_pkg::EV_RECORD_END |->
      prev_kind == csvt_pkg::EV_FIELD_END && prev_idx == events.field_index)
    else $error("record end not preceded by its field end");

  a_fe_consecutive: assert property (@(posedge clk) disable iff (rst)
    out_acc && events.event_kind == csvt_pkg::EV_FIELD_END &&
      prev_kind == csvt_pkg::EV_FIELD_END && !prev_last |->
      events.field_index == prev_idx + 1'b1)
    else $error("field ends within a run skip an index");

  a_data_nonzero: assert property (@(posedge clk) disable iff (rst)
    events.valid && events.event_kind == csvt_pkg::EV_DATA |-> events.field_byte != '0)
    else $error("zero byte delivered as field data");

  a_ctrl_zero_byte: assert property (@(posedge clk) disable iff (rst)
    events.valid && events.event_kind != csvt_pkg::EV_DATA |-> events.field_byte == '0)
    else $error("field or record end carries a byte");

endmodule

// ===== tb/csv_record_tokenizer_core_tb.sv =====
// Self-checking testbench for the CSV record tokenizer core.
module csv_record_tokenizer_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 300000;
  localparam int DRAIN_PAUSE = 8;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASE_BEATS = 10;
  localparam int NUM_PHASES  = 6;
  localparam int MAX_REPORTS = 40;

  typedef enum logic [7:0] {
    TS_STREAM_START = 8'b0000_0001,
    TS_HEADER       = 8'b0000_0010,
    TS_REC_START    = 8'b0000_0100,
    TS_FIELD_START  = 8'b0000_1000,
    TS_UNQUOTED     = 8'b0001_0000,
    TS_QUOTED       = 8'b0010_0000,
    TS_AFTER_QUOTE  = 8'b0100_0000,
    TS_SKIP_LINE    = 8'b1000_0000
  } tok_state_t;

  typedef enum logic [1:0] {
    SINK_OPEN,
    SINK_COIN,
    SINK_SPARSE,
    SINK_TOGGLE
  } sink_mode_t;

  typedef struct packed {
    csvt_pkg::ev_kind_t          kind;
    logic [csvt_pkg::FIDX_W-1:0] idx;
    logic [csvt_pkg::BYTE_W-1:0] data;
    logic                        last;
  } token_t;

  typedef struct packed {
    logic [csvt_pkg::BYTE_W-1:0] b;
    logic                        eod;
  } text_beat_t;

  logic clk = 1'b0;
  logic rst;

  csvt_in_if  bytes_ch ();
  csvt_out_if events_ch ();
  csvt_cfg_if cfg_ch ();

  csv_record_tokenizer_core u_top (
    .clk    (clk),
    .rst    (rst),
    .bytes  (bytes_ch),
    .events (events_ch),
    .cfg    (cfg_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Tokenizer state as predicted from accepted beats
  logic [csvt_pkg::FPR_W-1:0] cfg_fields;
  logic                       cfg_skip_hdr;
  tok_state_t                 tok_state;
  logic [csvt_pkg::FPR_W-1:0] cur_field;
  logic                       stream_ended;

  token_t     pending_tokens[$];
  text_beat_t byte_feed[$];

  int beats_left;
  int beats_queued;
  int beats_taken;
  int tokens_checked;
  int records_closed;
  int cfg_writes;
  int fail_count;
  int cycle_count;

  int         burst_left;
  int         gap_left;
  sink_mode_t sink_mode;
  int         mode_left;
  int         hold_left;
  logic       hold_done;
  logic       hold_req;

  function automatic int active_fields();
    if (cfg_fields == '0) return 1;
    if (cfg_fields > csvt_pkg::MAX_FIELDS) return csvt_pkg::MAX_FIELDS;
    return int'(cfg_fields);
  endfunction

  function automatic void add_token(csvt_pkg::ev_kind_t k, int idx,
                                    logic [csvt_pkg::BYTE_W-1:0] b);
    token_t t;
    t.kind = k;
    t.idx  = idx[csvt_pkg::FIDX_W-1:0];
    t.data = b;
    t.last = 1'b0;
    pending_tokens = {pending_tokens, t};
    if (k == csvt_pkg::EV_RECORD_END) records_closed++;
  endfunction

  // Returns 1 when the field just closed was the last of the record
  function automatic logic close_field();
    add_token(csvt_pkg::EV_FIELD_END, int'(cur_field), '0);
    if (int'(cur_field) + 1 >= active_fields()) begin
      add_token(csvt_pkg::EV_RECORD_END, int'(cur_field), '0);
      return 1'b1;
    end
    cur_field = cur_field + 1'b1;
    return 1'b0;
  endfunction

  // Close the current field, pad the rest of the record empty, then end it
  function automatic void close_record();
    int n;
    int last_idx;
    n = active_fields();
    last_idx = int'(cur_field);
    add_token(csvt_pkg::EV_FIELD_END, int'(cur_field), '0);
    for (int i = int'(cur_field) + 1; i < n; i++) begin
      add_token(csvt_pkg::EV_FIELD_END, i, '0);
      last_idx = i;
    end
    add_token(csvt_pkg::EV_RECORD_END, last_idx, '0);
  endfunction

  function automatic void field_char(logic [csvt_pkg::BYTE_W-1:0] b, logic at_start);
    if (at_start && b == csvt_pkg::CH_QUOTE) begin
      tok_state = TS_QUOTED;
    end else if (b == csvt_pkg::CH_COMMA) begin
      tok_state = close_field() ? TS_SKIP_LINE : TS_FIELD_START;
    end else if (b == csvt_pkg::CH_CR || b == csvt_pkg::CH_LF) begin
      close_record();
      tok_state = (b == csvt_pkg::CH_LF) ? TS_REC_START : TS_SKIP_LINE;
    end else begin
      add_token(csvt_pkg::EV_DATA, int'(cur_field), b);
      tok_state = TS_UNQUOTED;
    end
  endfunction

  function automatic void parse_byte(logic [csvt_pkg::BYTE_W-1:0] b);
    if (tok_state == TS_STREAM_START)
      tok_state = cfg_skip_hdr ? TS_HEADER : TS_REC_START;
    case (tok_state)
      TS_HEADER, TS_SKIP_LINE: begin
        if (b == csvt_pkg::CH_LF) tok_state = TS_REC_START;
      end
      TS_REC_START: begin
        if (b != csvt_pkg::CH_CR && b != csvt_pkg::CH_LF) begin
          cur_field = '0;
          field_char(b, 1'b1);
        end
      end
      TS_FIELD_START: field_char(b, 1'b1);
      TS_UNQUOTED:    field_char(b, 1'b0);
      TS_QUOTED: begin
        if (b == csvt_pkg::CH_QUOTE) tok_state = TS_AFTER_QUOTE;
        else add_token(csvt_pkg::EV_DATA, int'(cur_field), b);
      end
      default: begin
        // after a closing quote: a second quote is literal, a comma closes, anything else is stray
        if (b == csvt_pkg::CH_QUOTE) begin
          add_token(csvt_pkg::EV_DATA, int'(cur_field), csvt_pkg::CH_QUOTE);
          tok_state = TS_QUOTED;
        end else if (b == csvt_pkg::CH_COMMA) begin
          tok_state = close_field() ? TS_SKIP_LINE : TS_FIELD_START;
        end else if (close_field()) begin
          tok_state = (b == csvt_pkg::CH_LF) ? TS_REC_START : TS_SKIP_LINE;
        end else begin
          field_char(b, 1'b1);
        end
      end
    endcase
  endfunction

  function automatic void tokenize_beat(logic [csvt_pkg::BYTE_W-1:0] b, logic eod);
    int first;
    token_t t;
    first = pending_tokens.size();
    if (stream_ended) return;
    if (b != 8'h00) parse_byte(b);
    if (b == 8'h00 || eod) begin
      if (tok_state == TS_FIELD_START || tok_state == TS_UNQUOTED ||
          tok_state == TS_QUOTED || tok_state == TS_AFTER_QUOTE)
        close_record();
      if (tok_state == TS_STREAM_START)
        tok_state = cfg_skip_hdr ? TS_HEADER : TS_REC_START;
      else if (tok_state != TS_HEADER)
        tok_state = TS_REC_START;
      stream_ended = 1'b1;
    end
    // mark the newest prediction as the last of this byte's run
    if (pending_tokens.size() > first) begin
      t = pending_tokens[pending_tokens.size() - 1];
      t.last = 1'b1;
      pending_tokens[pending_tokens.size() - 1] = t;
    end
  endfunction

  function automatic void push_beat(logic [csvt_pkg::BYTE_W-1:0] b, logic eod = 1'b0);
    text_beat_t t;
    t.b   = b;
    t.eod = eod;
    byte_feed = {byte_feed, t};
    beats_left++;
    beats_queued++;
  endfunction

  function automatic void push_str(string s);
    for (int i = 0; i < s.len(); i++) push_beat(s[i]);
  endfunction

  function automatic logic [csvt_pkg::BYTE_W-1:0] plain_char(logic lead);
    logic [csvt_pkg::BYTE_W-1:0] c;
    do c = csvt_pkg::BYTE_W'($urandom_range(1, 255));
    while (c == csvt_pkg::CH_COMMA || c == csvt_pkg::CH_CR || c == csvt_pkg::CH_LF ||
           (lead && c == csvt_pkg::CH_QUOTE));
    return c;
  endfunction

  function automatic void push_field();
    int shape;
    int len;
    logic [csvt_pkg::BYTE_W-1:0] c;
    shape = $urandom_range(0, 9);
    if (shape < 2) return;
    if (shape < 6) begin
      len = $urandom_range(1, 4);
      for (int i = 0; i < len; i++) push_beat(plain_char(i == 0));
    end else begin
      push_beat(csvt_pkg::CH_QUOTE);
      len = $urandom_range(0, 4);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 5) == 0) begin
          push_beat(csvt_pkg::CH_QUOTE);
          push_beat(csvt_pkg::CH_QUOTE);
        end else begin
          do c = csvt_pkg::BYTE_W'($urandom_range(1, 255));
          while (c == csvt_pkg::CH_QUOTE);
          push_beat(c);
        end
      end
      push_beat(csvt_pkg::CH_QUOTE);
      if ($urandom_range(0, 4) == 0) push_beat(csvt_pkg::BYTE_W'($urandom_range(1, 255)));
    end
  endfunction

  // Mostly full records; some end early, some run past the field count.
  // Wide records mostly end early and are padded, to keep the stream short.
  function automatic void push_record(int n);
    int pick;
    int nf;
    pick = $urandom_range(0, 9);
    if (n > 6) begin
      if (pick == 0) nf = n + $urandom_range(0, 1);
      else nf = $urandom_range(1, 4);
    end else if (pick < 5) nf = n;
    else if (pick < 8) nf = $urandom_range(1, n);
    else nf = n + $urandom_range(1, 2);
    for (int i = 0; i < nf; i++) begin
      push_field();
      if (i < nf - 1) push_beat(csvt_pkg::CH_COMMA);
    end
    if ($urandom_range(0, 3) == 0) push_beat(csvt_pkg::CH_CR);
    push_beat(csvt_pkg::CH_LF);
  endfunction

  function automatic void fill_records(int target);
    int start;
    start = beats_queued;
    while (beats_queued - start < target) begin
      case ($urandom_range(0, 9))
        0: begin
          if ($urandom_range(0, 1) == 1) push_beat(csvt_pkg::CH_CR);
          push_beat(csvt_pkg::CH_LF);
        end
        1: repeat ($urandom_range(1, 3)) push_beat(csvt_pkg::BYTE_W'($urandom_range(1, 255)));
        default: push_record(active_fields());
      endcase
    end
  endfunction

  function automatic void check_field(string what, logic [csvt_pkg::BYTE_W-1:0] want_v,
                                      logic [csvt_pkg::BYTE_W-1:0] got_v);
    if (got_v !== want_v) begin
      if (fail_count < MAX_REPORTS)
        $display("%0t: %s mismatch, expected %h, got %h", $time, what, want_v, got_v);
      fail_count++;
    end
  endfunction

  // Wait until every beat is in and every event is out, then let the pipe settle
  task automatic settle();
    do @(posedge clk);
    while (beats_left != 0 || pending_tokens.size() != 0);
    repeat (DRAIN_PAUSE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [csvt_pkg::CFG_IDX_W-1:0] idx,
                           input logic [csvt_pkg::CFG_DATA_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk);
    while (cfg_ch.ready !== 1'b1);
    if (idx == csvt_pkg::CFG_FIELDS_PER_RECORD) cfg_fields = val[csvt_pkg::FPR_W-1:0];
    else if (idx == csvt_pkg::CFG_SKIP_HEADER) cfg_skip_hdr = val[0];
    cfg_writes++;
  endtask

  // Sender: bursts of beats with random gaps
  always @(posedge clk) begin : drive_text
    text_beat_t nxt;
    if (rst) begin
      bytes_ch.valid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (bytes_ch.valid && bytes_ch.ready) begin
        tokenize_beat(bytes_ch.data_byte, bytes_ch.end_of_data);
        beats_taken++;
        beats_left--;
      end
      if (!bytes_ch.valid || bytes_ch.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          bytes_ch.valid <= 1'b0;
        end else if (byte_feed.size() > 0) begin
          nxt = byte_feed.pop_front();
          bytes_ch.valid       <= 1'b1;
          bytes_ch.data_byte   <= nxt.b;
          bytes_ch.end_of_data <= nxt.eod;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          bytes_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: stall pattern is redrawn whenever its mode runs out; one long hold-off
  always @(posedge clk) begin : sink_tokens
    if (rst) begin
      events_ch.ready <= 1'b0;
      mode_left = 0;
      hold_left = 0;
      hold_done = 1'b0;
    end else begin
      if (hold_req && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (mode_left == 0) begin
        sink_mode = sink_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(16, 96);
      end else begin
        mode_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        events_ch.ready <= 1'b0;
      end else begin
        case (sink_mode)
          SINK_OPEN:   events_ch.ready <= 1'b1;
          SINK_COIN:   events_ch.ready <= 1'($urandom_range(0, 1));
          SINK_SPARSE: events_ch.ready <= ($urandom_range(0, 3) == 0);
          default:     events_ch.ready <= !events_ch.ready;
        endcase
      end
    end
  end

  // Compare every event beat with the oldest prediction
  always @(posedge clk) begin : check_tokens
    token_t want;
    if (!rst && events_ch.valid && events_ch.ready) begin
      if (pending_tokens.size() == 0) begin
        if (fail_count < MAX_REPORTS)
          $display("%0t: unexpected event kind %0d index %0d byte %h, expected none",
                   $time, events_ch.event_kind, events_ch.field_index, events_ch.field_byte);
        fail_count++;
      end else begin
        want = pending_tokens.pop_front();
        check_field("event_kind", csvt_pkg::BYTE_W'(want.kind),
                    csvt_pkg::BYTE_W'(events_ch.event_kind));
        check_field("field_index", csvt_pkg::BYTE_W'(want.idx),
                    csvt_pkg::BYTE_W'(events_ch.field_index));
        check_field("field_byte", want.data, events_ch.field_byte);
        check_field("last_of_run", csvt_pkg::BYTE_W'(want.last),
                    csvt_pkg::BYTE_W'(events_ch.last_of_run));
        tokens_checked++;
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: no finish after %0d cycles, %0d beats unsent, %0d events expected",
               $time, cycle_count, beats_left, pending_tokens.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    logic [csvt_pkg::CFG_DATA_W-1:0] fields_plan [NUM_PHASES];
    logic                            zero_end;

    rst = 1'b1;
    hold_req = 1'b0;
    bytes_ch.valid = 1'b0;
    bytes_ch.data_byte = '0;
    bytes_ch.end_of_data = 1'b0;
    events_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    cfg_fields = csvt_pkg::FPR_W'(6);
    cfg_skip_hdr = 1'b1;
    tok_state = TS_STREAM_START;
    cur_field = '0;
    stream_ended = 1'b0;
    beats_left = 0;
    beats_queued = 0;
    beats_taken = 0;
    tokens_checked = 0;
    records_closed = 0;
    cfg_writes = 0;
    fail_count = 0;
    cycle_count = 0;

    // extremes of the field count, a zero that acts as one, an oversize that clamps
    fields_plan[0] = 8'd1;
    fields_plan[1] = 8'd16;
    fields_plan[2] = 8'd0;
    fields_plan[3] = 8'd31;
    fields_plan[4] = 8'hE6;
    fields_plan[5] = csvt_pkg::CFG_DATA_W'($urandom_range(2, 15));

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // header skip is taken from the first byte; keep its reset value half the time
    write_reg(csvt_pkg::CFG_FIELDS_PER_RECORD, 8'd3);
    if ($urandom_range(0, 1) == 1) write_reg(csvt_pkg::CFG_SKIP_HEADER, 8'h00);
    cfg_ch.valid <= 1'b0;

    push_str("H,x\n");
    push_beat(csvt_pkg::CH_CR);
    push_beat(csvt_pkg::CH_LF);
    // quoted field holding a byte of all ones, a comma, a doubled quote and a newline
    push_beat(csvt_pkg::CH_QUOTE);
    push_beat(8'hFF);
    push_str(",\"\"\n\",");
    // quote inside an unquoted field
    push_beat(8'h01);
    push_str("\"b,");
    // stray byte after the closing quote of the last field, then ignored to LF
    push_str("\"q\"z\n");
    // CR straight after an empty quoted field pads the record
    push_str("\"\"");
    push_beat(csvt_pkg::CH_CR);
    push_beat(csvt_pkg::CH_LF);
    // last field closed by a comma, rest of the line dropped
    push_str(",,,x\n");
    settle();

    for (int p = 0; p < NUM_PHASES; p++) begin
      // bring the parser back to a record start before touching the registers
      if (tok_state != TS_REC_START) begin
        if (tok_state == TS_QUOTED) push_beat(csvt_pkg::CH_QUOTE);
        push_beat(csvt_pkg::CH_LF);
        settle();
      end
      write_reg(csvt_pkg::CFG_FIELDS_PER_RECORD, fields_plan[p]);
      write_reg(csvt_pkg::CFG_SKIP_HEADER,
                {7'($urandom_range(0, 127)), 1'($urandom_range(0, 1))});
      if (p == 2)
        write_reg(csvt_pkg::CFG_IDX_W'($urandom_range(int'(csvt_pkg::CFG_SKIP_HEADER) + 1,
                                                      15)),
                  csvt_pkg::CFG_DATA_W'($urandom_range(0, 255)));
      cfg_ch.valid <= 1'b0;
      fill_records(PHASE_BEATS);
      if (p == 1) hold_req <= 1'b1;
      settle();
    end

    // open a record, then end the stream by a zero byte or the end flag
    zero_end = 1'($urandom_range(0, 1));
    push_beat(plain_char(1'b1));
    push_beat(plain_char(1'b0));
    if (zero_end) push_beat(8'h00, 1'($urandom_range(0, 1)));
    else push_beat(csvt_pkg::BYTE_W'($urandom_range(1, 255)), 1'b1);
    // all of these must be dropped once the stream has ended
    push_beat(csvt_pkg::CH_LF);
    push_beat(csvt_pkg::BYTE_W'($urandom_range(1, 255)), 1'b1);
    push_beat(8'h00);
    settle();

    $display("Run covered %0d bytes under %0d register writes: %0d events checked, %0d records.",
             beats_taken, cfg_writes, tokens_checked, records_closed);
    $display("Stream closed by %s; receiver held off for %0d cycles once.",
             zero_end ? "a zero byte" : "the end flag", HOLD_CYCLES);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/csvt_pkg.sv
hdl/csvt_in_if.sv
hdl/csvt_out_if.sv
hdl/csvt_cfg_if.sv
hdl/csvt_parser.sv
hdl/csvt_emitter.sv
hdl/csv_record_tokenizer_core.sv
tb/csv_record_tokenizer_core_tb.sv
